>>> rtl/vfme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vfme_pkg;

    localparam int NUM_FACES      = 6;
    localparam int VERTS_PER_FACE = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_AIR_CODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLUID_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLASS_CODE = 2'd2;

    localparam logic [7:0] AIR_CODE_RESET   = 8'd0;
    localparam logic [7:0] FLUID_CODE_RESET = 8'd1;
    localparam logic [7:0] GLASS_CODE_RESET = 8'd2;

    localparam logic [2:0] LAST_VERT = 3'(VERTS_PER_FACE - 1);

    // Corner code per face: bit 0 is +x, bit 1 is +y, bit 2 is +z.
    localparam logic [2:0] CORNER_TAB [NUM_FACES][4] = '{
        '{3'd1, 3'd3, 3'd7, 3'd5},
        '{3'd4, 3'd6, 3'd2, 3'd0},
        '{3'd2, 3'd6, 3'd7, 3'd3},
        '{3'd4, 3'd0, 3'd1, 3'd5},
        '{3'd5, 3'd7, 3'd6, 3'd4},
        '{3'd0, 3'd2, 3'd3, 3'd1}
    };

    // Two triangles per face: corners 0,1,2 and 0,2,3.
    localparam logic [1:0] VERTEX_SLOT [VERTS_PER_FACE] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3
    };

    typedef struct packed {
        logic [7:0] local_x;
        logic [7:0] local_y;
        logic [7:0] local_z;
        logic [7:0] voxel_material;
        logic [7:0] pos_x_material;
        logic [7:0] neg_x_material;
        logic [7:0] pos_y_material;
        logic [7:0] neg_y_material;
        logic [7:0] pos_z_material;
        logic [7:0] neg_z_material;
    } voxel_in_t;

    typedef struct packed {
        logic [7:0] vertex_x;
        logic [7:0] vertex_y;
        logic [7:0] vertex_z;
        logic [7:0] vertex_material;
        logic [2:0] face_index;
        logic       last_vertex;
    } vertex_out_t;

    typedef struct packed {
        logic [7:0]           x;
        logic [7:0]           y;
        logic [7:0]           z;
        logic [7:0]           material;
        logic [NUM_FACES-1:0] face_mask;
    } voxel_job_t;

endpackage
`default_nettype wire

>>> rtl/vfme_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vfme_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [vfme_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vfme_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire vfme_pkg::voxel_in_t             voxel,
    output vfme_pkg::voxel_job_t                 job,
    output logic                                 keep
);
    import vfme_pkg::*;

    logic [7:0] air_code_reg;
    logic [7:0] fluid_code_reg;
    logic [7:0] glass_code_reg;

    logic [7:0]           nb [NUM_FACES];
    logic                 is_air;
    logic                 is_fluid;
    logic [NUM_FACES-1:0] mask;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            air_code_reg   <= AIR_CODE_RESET;
            fluid_code_reg <= FLUID_CODE_RESET;
            glass_code_reg <= GLASS_CODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_AIR_CODE:   air_code_reg   <= cfg_data;
                CFG_FLUID_CODE: fluid_code_reg <= cfg_data;
                CFG_GLASS_CODE: glass_code_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign nb[0] = voxel.pos_x_material;
    assign nb[1] = voxel.neg_x_material;
    assign nb[2] = voxel.pos_y_material;
    assign nb[3] = voxel.neg_y_material;
    assign nb[4] = voxel.pos_z_material;
    assign nb[5] = voxel.neg_z_material;

    // Air wins over fluid when both codes are equal.
    assign is_air   = (voxel.voxel_material == air_code_reg);
    assign is_fluid = (voxel.voxel_material == fluid_code_reg);

    always_comb
    begin
        for (int f = 0; f < NUM_FACES; f++)
        begin
            mask[f] = !is_air &&
                      ((nb[f] == air_code_reg) || (is_fluid && (nb[f] == glass_code_reg)));
        end
    end

    assign job.x         = voxel.local_x;
    assign job.y         = voxel.local_y;
    assign job.z         = voxel.local_z;
    assign job.material  = voxel.voxel_material;
    assign job.face_mask = mask;
    assign keep          = |mask;

endmodule
`default_nettype wire

>>> rtl/vfme_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module vfme_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire vfme_pkg::voxel_job_t wr_data,
    output logic                      full,
    input  wire logic                 rd_en,
    output logic                      rd_valid,
    output vfme_pkg::voxel_job_t      rd_data
);
    import vfme_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    voxel_job_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/vfme_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vfme_back #(
    parameter logic [7:0] COORD_MASK = 8'hFF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    input  wire vfme_pkg::voxel_job_t job,
    output logic                      job_take,
    output logic                      empty,
    input  wire logic                 pop,
    output vfme_pkg::vertex_out_t     vertex
);
    import vfme_pkg::*;

    voxel_job_t           job_reg;
    logic                 busy_reg;
    logic [NUM_FACES-1:0] mask_reg;
    logic [2:0]           vert_reg;
    vertex_out_t          out_reg;
    logic                 out_valid_reg;

    logic [2:0]           face_sel;
    logic [NUM_FACES-1:0] rest;
    logic [2:0]           corner;
    logic                 face_done;
    logic                 step;
    logic                 finish;
    vertex_out_t          out_next;

    // Lowest pending face goes first, which keeps the +x .. -z order.
    always_comb
    begin
        face_sel = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (mask_reg[f])
            begin
                face_sel = 3'(f);
            end
        end
    end

    assign rest      = mask_reg & (mask_reg - 1'b1);
    assign corner    = CORNER_TAB[face_sel][VERTEX_SLOT[vert_reg]];
    assign face_done = (vert_reg == LAST_VERT);
    assign step      = busy_reg && (!out_valid_reg || pop);
    assign finish    = step && face_done && (rest == '0);
    assign job_take  = job_valid && (!busy_reg || finish);

    always_comb
    begin
        out_next.vertex_x        = 8'(job_reg.x + 8'(corner[0])) & COORD_MASK;
        out_next.vertex_y        = 8'(job_reg.y + 8'(corner[1])) & COORD_MASK;
        out_next.vertex_z        = 8'(job_reg.z + 8'(corner[2])) & COORD_MASK;
        out_next.vertex_material = job_reg.material;
        out_next.face_index      = face_sel;
        out_next.last_vertex     = face_done && (rest == '0);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            vert_reg      <= '0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg <= 1'b1;
                mask_reg <= job.face_mask;
                vert_reg <= '0;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (step)
            begin
                if (face_done)
                begin
                    mask_reg <= rest;
                    vert_reg <= '0;
                end
                else
                begin
                    vert_reg <= vert_reg + 1'b1;
                end
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (job_take)
        begin
            job_reg <= job;
        end
        if (step)
        begin
            out_reg <= out_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign vertex = out_reg;

endmodule
`default_nettype wire

>>> rtl/voxel_face_mesh_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake              Payload
// voxel     push / full            voxel  (voxel_in_t)
// vertex    pop / empty            vertex (vertex_out_t)
// config    cfg_write              cfg_index, cfg_data
//
// A voxel yields six vertices per visible face, up to 36, from the back-end
// sequencer that emits one vertex per cycle while pop drains it. A voxel with no
// visible face is accepted and dropped. The front end classifies faces on the fly
// and parks up to two voxels in a queue, so input is taken while vertices drain.
// Reset restores the material codes to 0, 1 and 2 and empties queue and output.
// With pop held low the output register holds, the queue fills and full rises.
module voxel_face_mesh_emitter #(
    parameter int COORD_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire vfme_pkg::voxel_in_t               voxel,
    output logic                                   empty,
    input  wire logic                              pop,
    output vfme_pkg::vertex_out_t                  vertex,
    input  wire logic                              cfg_write,
    input  wire logic [vfme_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [vfme_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vfme_pkg::*;

    // Coordinates wrap at 2^COORD_BITS and are then cut to the 8-bit fields.
    localparam logic [7:0] COORD_MASK =
        (COORD_BITS >= 8) ? 8'hFF : 8'((1 << COORD_BITS) - 1);

    voxel_job_t front_job;
    logic       front_keep;
    logic       queue_full;
    logic       queue_valid;
    voxel_job_t queue_job;
    logic       queue_take;

    vfme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .voxel     (voxel),
        .job       (front_job),
        .keep      (front_keep)
    );

    vfme_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push && front_keep),
        .wr_data  (front_job),
        .full     (queue_full),
        .rd_en    (queue_take),
        .rd_valid (queue_valid),
        .rd_data  (queue_job)
    );

    vfme_back #(
        .COORD_MASK (COORD_MASK)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job       (queue_job),
        .job_take  (queue_take),
        .empty     (empty),
        .pop       (pop),
        .vertex    (vertex)
    );

    assign full = queue_full;

endmodule
`default_nettype wire
